### rtl/core/chm_pkg.sv
// Shared constants for the chained hash multimap core.
// Field widths, request mode codes and result status codes; no dependencies.
`default_nettype none

package chm_pkg;

    localparam int KEY_W  = 32;
    localparam int ITEM_W = 64;
    localparam int CFG_W  = 9;
    localparam int MODE_W = 2;
    localparam int ST_W   = 2;

    localparam logic [CFG_W-1:0] DEFAULT_BUCKETS = 9'd31;

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_DUP      = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

endpackage

`default_nettype wire

### rtl/core/chained_hash_multimap_core.sv
// Chained hash multimap: top level with request sequencer and node memories.
// Depends on chm_pkg and chm_ram.
`default_nettype none

// One request at a time. A request reduces the key modulo the bucket count
// (one quotient bit per cycle), fetches the chain head, reads each chain node
// visited (registered reads of the node link and key/item memories), leaves
// the walk when it ends without a match, pops the free stack for an insert,
// and loads the result register. Bucket heads carry per-entry valid bits and
// the free stack a low water mark, so no clearing pass runs after reset.
// num_buckets may only be changed while the table is empty and no request is
// in flight.
module chained_hash_multimap_core #(
    parameter int MAX_BUCKETS = 256,
    parameter int POOL_NODES  = 1024,
    localparam int HW = $clog2(POOL_NODES + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [chm_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [chm_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [chm_pkg::KEY_W-1:0]    i_key,
    input  wire logic [chm_pkg::ITEM_W-1:0]   i_item,
    input  wire logic [HW-1:0]                i_cursor,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [chm_pkg::ST_W-1:0]     o_status,
    output logic      [HW-1:0]                o_entry,
    output logic      [chm_pkg::KEY_W-1:0]    o_found_key,
    output logic      [chm_pkg::ITEM_W-1:0]   o_found_item,
    output logic      [HW-1:0]                o_item_count
);
    localparam int NI_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int BI_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int KEY_W = chm_pkg::KEY_W;
    localparam int ITEM_W = chm_pkg::ITEM_W;
    localparam int KV_W = KEY_W + ITEM_W;
    localparam int DW = chm_pkg::CFG_W + 1;
    localparam int DC_W = $clog2(KEY_W);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_HEAD, S_HEADW, S_WALK, S_CHK, S_POPW, S_RESP
    } t_state;

    t_state                     r_state;
    logic [chm_pkg::CFG_W-1:0]  r_cfg;
    logic [chm_pkg::MODE_W-1:0] r_mode;
    logic [KEY_W-1:0]           r_key;
    logic [ITEM_W-1:0]          r_item;
    logic [HW-1:0]              r_cursor;
    logic [KEY_W-1:0]           r_div_q;
    logic [DW-1:0]              r_rem;
    logic [DC_W-1:0]            r_div_cnt;
    logic [BI_W-1:0]            r_b;
    logic [HW-1:0]              r_h;
    logic [HW-1:0]              r_prev;
    logic [HW-1:0]              r_head;
    logic [HW-1:0]              r_steps;
    logic [HW-1:0]              r_free_top;
    logic [HW-1:0]              r_mark;
    logic [HW-1:0]              r_count;
    logic [MAX_BUCKETS-1:0]     r_bvalid;
    logic [chm_pkg::ST_W-1:0]   r_res_status;
    logic [HW-1:0]              r_res_entry;
    logic [KEY_W-1:0]           r_res_fkey;
    logic [ITEM_W-1:0]          r_res_fitem;
    logic                       r_out_valid;
    logic [chm_pkg::ST_W-1:0]   r_o_status;
    logic [HW-1:0]              r_o_entry;
    logic [KEY_W-1:0]           r_o_fkey;
    logic [ITEM_W-1:0]          r_o_fitem;
    logic [HW-1:0]              r_o_count;

    logic [DW-1:0]   w_nb;
    logic [DW-1:0]   w_trial;
    logic [DW-1:0]   n_rem;
    logic            w_walk_go;
    logic            w_key_eq;
    logic            w_kv_eq;
    logic            w_full;
    logic            w_can_push;
    logic [NI_W-1:0] w_pop_pos;
    logic            w_pop_init;
    logic [NI_W-1:0] w_idx;
    logic [HW-1:0]   w_head_eff;

    logic              bk_we;
    logic [BI_W-1:0]   bk_waddr;
    logic [HW-1:0]     bk_wdata;
    logic [HW-1:0]     bk_rdata;
    logic              nx_we;
    logic [NI_W-1:0]   nx_waddr;
    logic [HW-1:0]     nx_wdata;
    logic [NI_W-1:0]   nx_raddr;
    logic [HW-1:0]     nx_rdata;
    logic              kv_we;
    logic [KV_W-1:0]   kv_rdata;
    logic              fs_we;
    logic [NI_W-1:0]   fs_rdata;

    function automatic logic h_ok(input logic [HW-1:0] h);
        return (h != '0) && (h <= HW'(POOL_NODES));
    endfunction

    // effective bucket count: zero acts as one, clamp to the table size
    always_comb begin
        if (r_cfg == '0) begin
            w_nb = DW'(1);
        end else if (32'(r_cfg) > 32'(MAX_BUCKETS)) begin
            w_nb = DW'(MAX_BUCKETS);
        end else begin
            w_nb = {1'b0, r_cfg};
        end
    end

    assign w_trial = {r_rem[DW-2:0], r_div_q[KEY_W-1]};
    assign n_rem   = (w_trial >= w_nb) ? (w_trial - w_nb) : w_trial;

    assign w_walk_go  = h_ok(r_h) && (r_steps < HW'(POOL_NODES));
    assign w_key_eq   = (kv_rdata[KV_W-1:ITEM_W] == r_key);
    assign w_kv_eq    = w_key_eq && (kv_rdata[ITEM_W-1:0] == r_item);
    assign w_full     = (r_free_top == '0) || (r_free_top > HW'(POOL_NODES));
    assign w_can_push = (r_free_top < HW'(POOL_NODES));
    assign w_pop_pos  = NI_W'(r_free_top - HW'(1));
    // stack slots below the low water mark were never written; their initial index is computed instead
    assign w_pop_init = ((r_free_top - HW'(1)) < r_mark);
    assign w_idx      = w_pop_init ? (NI_W'(POOL_NODES - 1) - w_pop_pos) : fs_rdata;
    assign w_head_eff = r_bvalid[r_b] ? bk_rdata : '0;

    always_comb begin
        bk_we    = 1'b0;
        bk_waddr = r_b;
        bk_wdata = HW'(w_idx) + HW'(1);
        nx_we    = 1'b0;
        nx_waddr = w_idx;
        nx_wdata = r_head;
        nx_raddr = NI_W'(r_h - HW'(1));
        kv_we    = 1'b0;
        fs_we    = 1'b0;
        if (r_state == S_HEAD) begin
            nx_raddr = NI_W'(r_cursor - HW'(1));
        end
        if (r_state == S_POPW) begin
            bk_we = 1'b1;
            nx_we = 1'b1;
            kv_we = 1'b1;
        end
        if ((r_state == S_CHK) && (r_mode == chm_pkg::MODE_DELETE) && w_kv_eq) begin
            // unlink: splice the successor into the head or the previous node
            if (r_prev == '0) begin
                bk_we    = 1'b1;
                bk_wdata = nx_rdata;
            end else begin
                nx_we    = 1'b1;
                nx_waddr = NI_W'(r_prev - HW'(1));
                nx_wdata = nx_rdata;
            end
            fs_we = w_can_push;
        end
    end

    chm_ram #(.WIDTH(HW), .DEPTH(MAX_BUCKETS)) u_heads (
        .i_clk   (i_clk),
        .i_we    (bk_we),
        .i_waddr (bk_waddr),
        .i_wdata (bk_wdata),
        .i_raddr (r_b),
        .o_rdata (bk_rdata)
    );

    chm_ram #(.WIDTH(HW), .DEPTH(POOL_NODES)) u_next (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_raddr (nx_raddr),
        .o_rdata (nx_rdata)
    );

    chm_ram #(.WIDTH(KV_W), .DEPTH(POOL_NODES)) u_kv (
        .i_clk   (i_clk),
        .i_we    (kv_we),
        .i_waddr (w_idx),
        .i_wdata ({r_key, r_item}),
        .i_raddr (NI_W'(r_h - HW'(1))),
        .o_rdata (kv_rdata)
    );

    chm_ram #(.WIDTH(NI_W), .DEPTH(POOL_NODES)) u_free (
        .i_clk   (i_clk),
        .i_we    (fs_we),
        .i_waddr (NI_W'(r_free_top)),
        .i_wdata (NI_W'(r_h - HW'(1))),
        .i_raddr (w_pop_pos),
        .o_rdata (fs_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= chm_pkg::DEFAULT_BUCKETS;
            r_free_top  <= HW'(POOL_NODES);
            r_mark      <= HW'(POOL_NODES);
            r_count     <= '0;
            r_bvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (r_out_valid && !i_out_stall && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode    <= i_mode;
                        r_key     <= i_key;
                        r_item    <= i_item;
                        r_cursor  <= i_cursor;
                        r_div_q   <= i_key;
                        r_rem     <= '0;
                        r_div_cnt <= '0;
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem     <= n_rem;
                    r_div_q   <= {r_div_q[KEY_W-2:0], 1'b0};
                    r_div_cnt <= r_div_cnt + DC_W'(1);
                    if (r_div_cnt == DC_W'(KEY_W - 1)) begin
                        r_b     <= BI_W'(n_rem);
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_res_status <= chm_pkg::ST_NOTFOUND;
                    r_res_entry  <= '0;
                    r_res_fkey   <= '0;
                    r_res_fitem  <= '0;
                    if ((r_mode == chm_pkg::MODE_LOOKUP) || (r_mode == chm_pkg::MODE_INSERT)
                        || (r_mode == chm_pkg::MODE_DELETE)) begin
                        r_state <= S_HEADW;
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                S_HEADW: begin
                    r_head  <= w_head_eff;
                    r_prev  <= '0;
                    r_steps <= '0;
                    if ((r_mode != chm_pkg::MODE_LOOKUP) || (r_cursor == '0)) begin
                        r_h <= w_head_eff;
                    end else if (h_ok(r_cursor)) begin
                        r_h <= nx_rdata;
                    end else begin
                        r_h <= '0;
                    end
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (w_walk_go) begin
                        r_state <= S_CHK;
                    end else if (r_mode == chm_pkg::MODE_INSERT) begin
                        if (w_full) begin
                            r_res_status <= chm_pkg::ST_FULL;
                            r_state      <= S_RESP;
                        end else begin
                            r_state <= S_POPW;
                        end
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                S_CHK: begin
                    priority if ((r_mode == chm_pkg::MODE_LOOKUP) && w_key_eq) begin
                        r_res_status <= chm_pkg::ST_OK;
                        r_res_entry  <= r_h;
                        r_res_fkey   <= r_key;
                        r_res_fitem  <= kv_rdata[ITEM_W-1:0];
                        r_state      <= S_RESP;
                    end else if ((r_mode == chm_pkg::MODE_INSERT) && w_kv_eq) begin
                        r_res_status <= chm_pkg::ST_DUP;
                        r_state      <= S_RESP;
                    end else if ((r_mode == chm_pkg::MODE_DELETE) && w_kv_eq) begin
                        if (w_can_push) begin
                            r_free_top <= r_free_top + HW'(1);
                        end
                        if (r_count != '0) begin
                            r_count <= r_count - HW'(1);
                        end
                        r_res_status <= chm_pkg::ST_OK;
                        r_res_entry  <= r_h;
                        r_state      <= S_RESP;
                    end else begin
                        // advance along the chain
                        r_prev  <= r_h;
                        r_h     <= nx_rdata;
                        r_steps <= r_steps + HW'(1);
                        r_state <= S_WALK;
                    end
                end
                S_POPW: begin
                    r_bvalid[r_b] <= 1'b1;
                    r_free_top    <= r_free_top - HW'(1);
                    if ((r_free_top - HW'(1)) < r_mark) begin
                        r_mark <= r_free_top - HW'(1);
                    end
                    r_count      <= r_count + HW'(1);
                    r_res_status <= chm_pkg::ST_OK;
                    r_res_entry  <= HW'(w_idx) + HW'(1);
                    r_state      <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_res_status;
                        r_o_entry   <= r_res_entry;
                        r_o_fkey    <= r_res_fkey;
                        r_o_fitem   <= r_res_fitem;
                        r_o_count   <= r_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_o_status;
    assign o_entry      = r_o_entry;
    assign o_found_key  = r_o_fkey;
    assign o_found_item = r_o_fitem;
    assign o_item_count = r_o_count;

    a_pool_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) + 32'(r_free_top)) == 32'(POOL_NODES))
        else $error("stored count and free stack depth disagree");

    a_mark_below_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mark <= r_free_top)
        else $error("free stack top fell below its low water mark");

    a_chk_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> ($past(r_state) == S_WALK))
        else $error("node compare without a node fetch");

endmodule

`default_nettype wire

### rtl/core/chm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic [AW-1:0]        i_raddr,
    output logic      [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
